### rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sigmoid interpolator package
// Shared constants and the sigmoid ROM contents, built at elaboration time
// with exact integer arithmetic.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int LUT_BITS_DEF = 8;
  localparam int Q_FRAC       = 14;
  localparam int SPAN         = 131072;
  localparam int ROM_IDX_W    = 8;
  localparam int ROM_DEPTH    = 1 << ROM_IDX_W;
  localparam int HALF_DEPTH   = ROM_DEPTH / 2;
  localparam int SIG_W        = 15;
  localparam int SAMPLE_W     = 32;
  localparam int ARG_W        = 18;

  typedef logic [SIG_W-1:0] sig_rom_t [ROM_DEPTH];

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] mul_shr60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] term;
    logic [63:0] growth;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    logic [SIG_W-1:0] neg_half [HALF_DEPTH+1];
    term   = 64'd1 << 60;
    growth = term;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term   = udiv64(term, 64'(16 * n));
        growth = growth + term;
      end
    end
    e = 64'd1 << 48;
    for (int k = 0; k <= HALF_DEPTH; k++) begin
      d           = (64'd1 << 48) + e;
      q           = udiv64((64'd1 << 62) + (d >> 1), d);
      neg_half[k] = q[SIG_W-1:0];
      e           = mul_shr60(e, growth);
    end
    for (int m = 0; m < ROM_DEPTH; m++) begin
      if (m < HALF_DEPTH) begin
        rom[m] = neg_half[HALF_DEPTH-m];
      end else begin
        rom[m] = SIG_W'(16384) - neg_half[m-HALF_DEPTH];
      end
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

### rtl/sigmoid_lut_interpolator.sv
// ----------------------------------------------------------------------------
// Sigmoid LUT interpolator
// Throughput: one word per cycle unless out_ready stalls the output.
// The five register stages each hold one word and advance independently,
// so bubbles are squeezed out under stall.
// Reset: synchronous, active low; clears the stage valid bits only.
// Q14 sigmoid by table lookup with linear interpolation between entries.
// ----------------------------------------------------------------------------
module sigmoid_lut_interpolator
  import sli_pkg::*;
#(
  parameter int LUT_BITS = LUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SIG_W-1:0]    out_sigmoid_out
);

  localparam int NSTG    = 5;
  localparam int FRAC_W  = ARG_W - LUT_BITS;
  localparam int STEP    = 1 << FRAC_W;
  localparam int NUM_W   = 30;
  localparam int GRAD_W  = NUM_W - FRAC_W;
  localparam int PROD_W  = GRAD_W + FRAC_W + 1;
  localparam int CORR_W  = PROD_W - Q_FRAC;
  localparam int SUM_W   = CORR_W + 1;
  localparam int LAST    = (1 << LUT_BITS) - 1;

  localparam logic signed [SAMPLE_W-1:0] HI_LIM  = SAMPLE_W'(SPAN - STEP);
  localparam logic signed [SAMPLE_W-1:0] LO_LIM  = -SAMPLE_W'(SPAN);
  localparam logic signed [NUM_W-1:0]    HALF    = NUM_W'(STEP / 2);
  localparam logic signed [NUM_W-1:0]    STEP_M1 = NUM_W'(STEP - 1);
  localparam logic signed [PROD_W-1:0]   RND     = PROD_W'(1 << (Q_FRAC - 1));

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [SIG_W-1:0]           s2_lo_r, s2_hi_r;
  logic [FRAC_W-1:0]          s2_frac_r;
  logic signed [GRAD_W-1:0]   s3_grad_r;
  logic [SIG_W-1:0]           s3_lo_r;
  logic [FRAC_W-1:0]          s3_frac_r;
  logic signed [PROD_W-1:0]   s4_prod_r;
  logic [SIG_W-1:0]           s4_lo_r;
  logic [SIG_W-1:0]           s5_y_r;

  logic [SIG_W-1:0]           s2_lo_nxt, s2_hi_nxt;
  logic [FRAC_W-1:0]          s2_frac_nxt;
  logic signed [GRAD_W-1:0]   s3_grad_nxt;
  logic signed [PROD_W-1:0]   s4_prod_nxt;
  logic [SIG_W-1:0]           s5_y_nxt;

  logic [ARG_W-1:0]           biased;
  logic [LUT_BITS-1:0]        pos;
  logic [ROM_IDX_W-1:0]       idx_lo, idx_hi;
  logic signed [SIG_W:0]      diff;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    num_adj;
  logic signed [CORR_W-1:0]   corr;
  logic signed [SUM_W-1:0]    sum;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign in_ready        = en[0];
  assign out_valid       = vld_r[NSTG-1];
  assign out_sigmoid_out = s5_y_r;

  always_comb begin
    biased = s1_sample_r[ARG_W-1:0] ^ ARG_W'(SPAN);
    pos    = biased[ARG_W-1:FRAC_W];
    idx_lo = ROM_IDX_W'(pos) << (ROM_IDX_W - LUT_BITS);
    idx_hi = ROM_IDX_W'(LUT_BITS'(pos + LUT_BITS'(1))) << (ROM_IDX_W - LUT_BITS);
    if (s1_sample_r >= HI_LIM) begin
      s2_lo_nxt   = SIG_ROM[ROM_IDX_W'(LAST) << (ROM_IDX_W - LUT_BITS)];
      s2_hi_nxt   = s2_lo_nxt;
      s2_frac_nxt = '0;
    end else if (s1_sample_r <= LO_LIM) begin
      s2_lo_nxt   = SIG_ROM[0];
      s2_hi_nxt   = s2_lo_nxt;
      s2_frac_nxt = '0;
    end else begin
      s2_lo_nxt   = SIG_ROM[idx_lo];
      s2_hi_nxt   = SIG_ROM[idx_hi];
      s2_frac_nxt = biased[FRAC_W-1:0];
    end
  end

  always_comb begin
    diff = $signed({1'b0, s2_hi_r}) - $signed({1'b0, s2_lo_r});
    num  = $signed({diff[NUM_W-Q_FRAC-1:0], {Q_FRAC{1'b0}}});
    if (num >= 0) begin
      num_adj     = num + HALF;
      s3_grad_nxt = GRAD_W'(num_adj >>> FRAC_W);
    end else begin
      num_adj     = num - HALF + STEP_M1;
      s3_grad_nxt = GRAD_W'(num_adj >>> FRAC_W);
    end
  end

  always_comb begin
    s4_prod_nxt = PROD_W'(s3_grad_r) * PROD_W'($signed({1'b0, s3_frac_r}));
  end

  always_comb begin
    corr     = CORR_W'((s4_prod_r + RND) >>> Q_FRAC);
    sum      = $signed(SUM_W'(s4_lo_r)) + SUM_W'(corr);
    s5_y_nxt = sum[SIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sample_r <= in_sample_in;
    end
    if (en[1]) begin
      s2_lo_r   <= s2_lo_nxt;
      s2_hi_r   <= s2_hi_nxt;
      s2_frac_r <= s2_frac_nxt;
    end
    if (en[2]) begin
      s3_grad_r <= s3_grad_nxt;
      s3_lo_r   <= s2_lo_r;
      s3_frac_r <= s2_frac_r;
    end
    if (en[3]) begin
      s4_prod_r <= s4_prod_nxt;
      s4_lo_r   <= s3_lo_r;
    end
    if (en[4]) begin
      s5_y_r <= s5_y_nxt;
    end
  end

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sigmoid_out <= SIG_W'(16384))
    else $error("sigmoid output above one");

  a_rom_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> s2_hi_r >= s2_lo_r)
    else $error("table neighbors out of order");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input blocked with a free pipeline stage");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output word valid right after reset");

endmodule

### tb/sigmoid_result_checker.sv
// ----------------------------------------------------------------------------
// Sigmoid result checker
// Watches both channels of the sigmoid interpolator, predicts the Q14 sigmoid
// of every accepted sample from its own copy of the table, and compares each
// output word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module sigmoid_result_checker
  import sli_pkg::*;
#(
  parameter int LUT_BITS = LUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SIG_W-1:0]    out_sigmoid_out,
  output int                  mismatches,
  output int                  outstanding,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 1 << LUT_BITS;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [SIG_W-1:0]    sigmoid;
  } sigmoid_pred_t;

  int unsigned   fine_table [256];
  sigmoid_pred_t pending_sigmoid [$];

  // The fine table holds round(16384 * sigmoid((m - 128) / 16)) using exact
  // integer arithmetic, with e^(1/16) kept in Q60 and e^(k/16) in Q48.
  initial begin : fill_table
    longint unsigned term;
    longint unsigned growth;
    longint unsigned ex;
    longint unsigned den;
    logic [127:0]    prod;
    int unsigned     neg_half [129];
    term   = 64'd1 << 60;
    growth = term;
    for (int n = 1; n < 40; n++) begin
      if (term != 0) begin
        term   = term / longint'(16 * n);
        growth = growth + term;
      end
    end
    ex = 64'd1 << 48;
    for (int k = 0; k <= 128; k++) begin
      den         = (64'd1 << 48) + ex;
      neg_half[k] = 32'(((64'd1 << 62) + (den >> 1)) / den);
      prod        = 128'(ex) * 128'(growth);
      ex          = prod[123:60];
    end
    for (int m = 0; m < 256; m++) begin
      if (m < 128) begin
        fine_table[m] = neg_half[128 - m];
      end else begin
        fine_table[m] = 16384 - neg_half[m - 128];
      end
    end
  end

  function automatic longint table_entry(int unsigned idx);
    return longint'(fine_table[(idx << (8 - LUT_BITS)) & 255]);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [SIG_W-1:0] predict_sigmoid(logic [SAMPLE_W-1:0] raw);
    longint      x;
    longint      step;
    longint      lo_y;
    longint      hi_y;
    longint      num;
    longint      grad;
    longint      frac;
    longint      res;
    int unsigned biased;
    int unsigned pos;
    int          sh;
    sh   = ARG_W - LUT_BITS;
    step = longint'(1) << sh;
    x    = longint'(signed'(raw));
    if (x >= SPAN - step) begin
      res = table_entry(ENTRIES - 1);
    end else if (x <= -SPAN) begin
      res = table_entry(0);
    end else begin
      biased = 32'(x + SPAN);
      pos    = biased >> sh;
      lo_y   = table_entry(pos);
      hi_y   = table_entry(pos + 1);
      num    = (hi_y - lo_y) * 16384;
      if (num >= 0) begin
        num = num + (step >>> 1);
      end else begin
        num = num - (step >>> 1);
      end
      grad = sat32(num / step);
      frac = longint'(biased) & (step - 1);
      res  = lo_y + sat32((grad * frac + 8192) >>> Q_FRAC);
    end
    return res[SIG_W-1:0];
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  always @(posedge clk) begin : watch
    sigmoid_pred_t head;
    if (!rst_n) begin
      pending_sigmoid.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_sigmoid.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: output word %0d arrived with no sample pending",
                     $realtime, out_sigmoid_out);
          end
          mismatches++;
        end else begin
          head = pending_sigmoid.pop_front();
          checked++;
          if (out_sigmoid_out !== head.sigmoid) begin
            if (mismatches < 10) begin
              $display("%0t: sample %h sigmoid expected %0d got %0d",
                       $realtime, head.sample, head.sigmoid, out_sigmoid_out);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_sigmoid.push_back('{sample: in_sample_in,
                                    sigmoid: predict_sigmoid(in_sample_in)});
      end
    end
    outstanding = pending_sigmoid.size();
  end

endmodule

### tb/tb_sigmoid_lut_interpolator.sv
// ----------------------------------------------------------------------------
// Sigmoid LUT interpolator testbench
// Drives directed and random Q14 samples into the interpolator with random
// gaps and output stalls, including one long output stall and one drain
// pause, while a separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_sigmoid_lut_interpolator
  import sli_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP        = 1 << (ARG_W - LUT_BITS_DEF);
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1200;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] in_sample_in;
  logic                out_valid;
  logic                out_ready;
  logic [SIG_W-1:0]    out_sigmoid_out;

  int mismatches;
  int outstanding;
  int checked;
  int sent;
  int directed_sent;
  bit tx_gaps_on;
  bit rx_stalls_on;
  bit hold_off_req;

  sigmoid_lut_interpolator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sigmoid_out (out_sigmoid_out)
  );

  sigmoid_result_checker #(
    .LUT_BITS (LUT_BITS_DEF)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sigmoid_out (out_sigmoid_out),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .checked         (checked)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      v = int'($urandom_range(0, 2 * SPAN + 4 * STEP)) - (SPAN + 2 * STEP);
    end else if (r < 75) begin
      v = ($urandom_range(0, 1) ? SPAN - STEP : -SPAN) + int'($urandom_range(0, 8)) - 4;
    end else if (r < 85) begin
      v = int'($urandom_range(0, 255)) * STEP - SPAN;
      case ($urandom_range(0, 3))
        0: v = v + 1;
        1: v = v + STEP / 2;
        2: v = v + STEP - 1;
        default: v = v;
      endcase
    end else begin
      return $urandom();
    end
    return SAMPLE_W'(v);
  endfunction

  task automatic send_word(input logic [SAMPLE_W-1:0] value);
    int gap;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_in <= value;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_sample_in <= $urandom();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 99) < 30) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed_words [$];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    out_ready    = 1'b0;
    sent         = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       SAMPLE_W'(-SPAN), SAMPLE_W'(-SPAN + 1), SAMPLE_W'(-SPAN - 1),
                       SAMPLE_W'(SPAN - STEP), SAMPLE_W'(SPAN - STEP - 1),
                       SAMPLE_W'(SPAN - STEP + 1), SAMPLE_W'(SPAN), 32'h0000_0001,
                       SAMPLE_W'(16384), SAMPLE_W'(-16384), SAMPLE_W'(STEP - 1),
                       SAMPLE_W'(STEP), SAMPLE_W'(STEP / 2), SAMPLE_W'(-SPAN + STEP / 2),
                       SAMPLE_W'(-STEP / 2), 32'h5555_5555, 32'hAAAA_AAAA,
                       32'h0001_FFFF, 32'h8000_0001, SAMPLE_W'(-SPAN + STEP - 1)};
    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end
    directed_sent = sent;

    // Let everything drain before the output side freezes.
    go_quiet();
    wait (outstanding == 0);

    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_word(random_sample());
    tx_gaps_on = 1'b1;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        tx_gaps_on   = (i == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
        rx_stalls_on = (i == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
      end
      send_word(random_sample());
    end

    go_quiet();
    wait (outstanding == 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d samples (%0d directed, the rest random across and beyond the table).",
             sent, directed_sent);
    $display("Checked %0d sigmoid words, with one long output stall and one drain pause.",
             checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sigmoid_lut_interpolator.f
rtl/sli_pkg.sv
rtl/sigmoid_lut_interpolator.sv
tb/sigmoid_result_checker.sv
tb/tb_sigmoid_lut_interpolator.sv
